/* sv/hafr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hafr_pkg: shared types, constants and a function
// Codes, limits and the bytewise CRC-16/X.25 update for the HDLC receiver.
// ----------------------------------------------------------------------------
package hafr_pkg;

	// Frame size limits.
	localparam int unsigned MAX_FRAME_BYTES = 2048;
	localparam int unsigned COUNT_W         = 12;
	localparam logic [COUNT_W-1:0] MAX_FRAME_LIMIT = COUNT_W'(MAX_FRAME_BYTES);
	localparam logic [COUNT_W-1:0] CFG_RESET_LEN   = 12'd2048;

	// Line codes.
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;

	// CRC-16/X.25, reflected.
	localparam logic [15:0] CRC_START     = 16'hFFFF;
	localparam logic [15:0] CRC_GOOD      = 16'hF0B8;
	localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_FRAME_LENGTH = 2'd0;

	// Receiver mode.
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RX   = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_ERR  = 2'd3
	} rx_mode_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_DROP = 2'd2
	} kind_t;

	// One result item.
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         data;
		logic               crc_ok;
		logic [COUNT_W-1:0] length;
	} result_t;

	// Fold one byte into the running CRC, LSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* sv/hafr_apb_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hafr_apb_regs: configuration register file
// Holds max_frame_length behind an APB-style port and gives the frame limit
// in force, the smaller of the register and the built-in maximum.
// ----------------------------------------------------------------------------
module hafr_apb_regs
	import hafr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output logic [COUNT_W-1:0]  frame_limit
);

	logic [COUNT_W-1:0] max_len_q;
	logic               wr_en;

	// Word address of the access; only one register exists.
	assign wr_en  = psel && penable && pwrite && (paddr == REG_MAX_FRAME_LENGTH);
	assign pready = 1'b1;

	// Register write in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= CFG_RESET_LEN;
		end else if (wr_en) begin
			max_len_q <= pwdata[COUNT_W-1:0];
		end
	end

	// Read-back, zero extended.
	assign prdata = {{(32-COUNT_W){1'b0}}, max_len_q};

	// Limit in force.
	assign frame_limit = (max_len_q > MAX_FRAME_LIMIT) ? MAX_FRAME_LIMIT : max_len_q;

endmodule

/* sv/hafr_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hafr_deframer: destuffing and framing state machine
// Decodes one line byte per advance, updates mode, count and CRC, and
// reports the result item it causes, if any.
// ----------------------------------------------------------------------------
module hafr_deframer
	import hafr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         byte_s1,
	input  logic               advance,
	input  logic [COUNT_W-1:0] frame_limit,
	output logic               has_result,
	output result_t            result
);

	rx_mode_t           mode_q, mode_d;
	logic [15:0]        crc_q, crc_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               prev_flag_q;
	logic               is_flag;
	logic               is_esc;
	logic [7:0]         data_in;
	logic               at_limit;

	assign is_flag  = (byte_s1 == FLAG_BYTE);
	assign is_esc   = (byte_s1 == ESC_BYTE);
	assign data_in  = (mode_q == MODE_ESC) ? (byte_s1 ^ ESC_XOR) : byte_s1;
	assign at_limit = (count_q >= frame_limit);

	// State registers, updated when the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			crc_q       <= CRC_START;
			count_q     <= '0;
			prev_flag_q <= 1'b0;
		end else if (advance) begin
			mode_q      <= mode_d;
			crc_q       <= crc_d;
			count_q     <= count_d;
			prev_flag_q <= is_flag;
		end
	end

	// Next state and result for the item in the input register.
	always_comb begin
		mode_d        = mode_q;
		crc_d         = crc_q;
		count_d       = count_q;
		has_result    = 1'b0;
		result.kind   = KIND_DATA;
		result.data   = 8'h00;
		result.crc_ok = 1'b0;
		result.length = '0;
		unique case (mode_q)
			MODE_IDLE, MODE_ERR: begin
				if (is_flag) begin
					mode_d  = MODE_RX;
					crc_d   = CRC_START;
					count_d = '0;
				end
			end
			MODE_RX, MODE_ESC: begin
				if (is_flag) begin
					// Repeated flags in receive mode are ignored.
					if (mode_q == MODE_ESC || !prev_flag_q) begin
						has_result = 1'b1;
						if (mode_q == MODE_RX && count_q >= COUNT_W'(2)) begin
							result.kind   = KIND_END;
							result.crc_ok = (crc_q == CRC_GOOD);
							result.length = count_q;
						end else begin
							result.kind = KIND_DROP;
						end
						mode_d  = MODE_RX;
						crc_d   = CRC_START;
						count_d = '0;
					end
				end else if (mode_q == MODE_RX && is_esc) begin
					mode_d = MODE_ESC;
				end else begin
					// Destuffed data byte, or overflow at the limit.
					has_result = 1'b1;
					if (at_limit) begin
						mode_d      = MODE_ERR;
						result.kind = KIND_DROP;
					end else begin
						mode_d      = MODE_RX;
						count_d     = count_q + COUNT_W'(1);
						crc_d       = crc_byte(crc_q, data_in);
						result.kind = KIND_DATA;
						result.data = data_in;
					end
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
	end

endmodule

/* sv/hdlc_async_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_async_frame_receiver: byte-stuffed HDLC deframer with CRC-16/X.25
//
// The line channel (line_byte, line_valid, line_ready) takes one stuffed
// line byte per item. The result channel (result_kind, data_byte, crc_ok,
// frame_length, result_valid, result_ready) gives zero or one item per
// line byte: a destuffed data byte, a frame end with CRC status and length,
// or a frame drop. Frame bytes are streamed and never buffered.
// A line byte is taken into an input register and decoded there, and its
// result is written to the output register as the byte moves on; a held
// result can stall it in between. Throughput is one line byte per cycle
// while no held result stalls; the limit is the decode and bytewise CRC
// update between the two registers. While result_ready is low a held result
// stalls only line bytes that make a result; bytes that make none, such as
// escapes and idle or repeated flags, still drain, and line_ready drops once
// the input register holds a byte that cannot move on.
// Reset (arst_n low) empties both registers, returns the receiver to idle
// and sets max_frame_length to 2048. The APB register may be written only
// while no line byte is in flight.
// ----------------------------------------------------------------------------
module hdlc_async_frame_receiver
	import hafr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Line channel
	input  logic [7:0]         line_byte,
	input  logic               line_valid,
	output logic               line_ready,
	// Result channel
	output logic [1:0]         result_kind,
	output logic [7:0]         data_byte,
	output logic               crc_ok,
	output logic [COUNT_W-1:0] frame_length,
	output logic               result_valid,
	input  logic               result_ready
);

	logic [COUNT_W-1:0] frame_limit;
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               valid_s2;
	result_t            result_s2;
	logic               has_result;
	result_t            result;
	logic               out_free;
	logic               advance;

	hafr_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.frame_limit (frame_limit)
	);

	hafr_deframer u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_s1     (byte_s1),
		.advance     (advance),
		.frame_limit (frame_limit),
		.has_result  (has_result),
		.result      (result)
	);

	// Handshake: an item moves on when its result has room or it makes none.
	assign out_free   = !valid_s2 || result_ready;
	assign advance    = valid_s1 && (!has_result || out_free);
	assign line_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_ready) begin
			valid_s1 <= line_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_ready && line_valid) begin
			byte_s1 <= line_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && has_result) begin
			result_s2 <= result;
		end
	end

	assign result_valid = valid_s2;
	assign result_kind  = result_s2.kind;
	assign data_byte    = result_s2.data;
	assign crc_ok       = result_s2.crc_ok;
	assign frame_length = result_s2.length;

endmodule
